@@ rtl/core/c24h_pkg.sv @@
`default_nettype none

package c24h_pkg;

	// Time-of-day limits
	localparam int unsigned DaySeconds    = 86400;
	localparam int unsigned HourSeconds   = 3600;
	localparam int unsigned MinuteSeconds = 60;
	localparam int unsigned LastHour      = 23;
	localparam int unsigned LastMinute    = 59;
	localparam int unsigned LastSecond    = 59;

	localparam int unsigned SecWidth    = 17;
	localparam int unsigned HourWidth   = 5;
	localparam int unsigned MinWidth    = 6;
	localparam int unsigned NumButtons  = 4;
	localparam int unsigned NumDigits   = 4;

	localparam logic [7:0] ActionMapReset = 8'd78;

	// Segment bit positions, active high
	localparam logic [7:0] SegA = 8'h40;
	localparam logic [7:0] SegB = 8'h20;
	localparam logic [7:0] SegC = 8'h08;
	localparam logic [7:0] SegD = 8'h10;
	localparam logic [7:0] SegE = 8'h04;
	localparam logic [7:0] SegF = 8'h80;
	localparam logic [7:0] SegG = 8'h01;

	typedef logic [7:0] seg_t;

	// Per-button action codes
	typedef enum logic [1:0] {
		ACT_HOUR_UP   = 2'd0,
		ACT_HOUR_DOWN = 2'd1,
		ACT_MIN_UP    = 2'd2,
		ACT_MIN_DOWN  = 2'd3
	} action_t;

	typedef struct packed {
		logic [HourWidth-1:0] hrs;
		logic [MinWidth-1:0]  mins;
	} hm_t;

	// Seven-segment pattern of one decimal digit, blank for non-digits
	function automatic seg_t glyph(input logic [3:0] d);
		seg_t g;
		unique case (d)
			4'd0:    g = SegA | SegB | SegC | SegD | SegE | SegF;
			4'd1:    g = SegB | SegC;
			4'd2:    g = SegA | SegB | SegG | SegE | SegD;
			4'd3:    g = SegA | SegB | SegG | SegC | SegD;
			4'd4:    g = SegF | SegG | SegB | SegC;
			4'd5:    g = SegA | SegF | SegG | SegC | SegD;
			4'd6:    g = SegA | SegF | SegG | SegE | SegC | SegD;
			4'd7:    g = SegA | SegB | SegC;
			4'd8:    g = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
			4'd9:    g = SegA | SegB | SegC | SegD | SegF | SegG;
			default: g = '0;
		endcase
		return g;
	endfunction

	// Tens digit of a value below 60
	function automatic logic [2:0] tens_of(input logic [MinWidth-1:0] v);
		logic [2:0] t;
		if (v >= MinWidth'(50))      t = 3'd5;
		else if (v >= MinWidth'(40)) t = 3'd4;
		else if (v >= MinWidth'(30)) t = 3'd3;
		else if (v >= MinWidth'(20)) t = 3'd2;
		else if (v >= MinWidth'(10)) t = 3'd1;
		else                         t = 3'd0;
		return t;
	endfunction

	// Ones digit of a value below 60
	function automatic logic [3:0] ones_of(input logic [MinWidth-1:0] v);
		logic [MinWidth-1:0] r;
		r = v - MinWidth'(tens_of(v)) * MinWidth'(10);
		return r[3:0];
	endfunction

	// One set-button action on hours and minutes; crossing midnight
	// upward lands on 00:00, downward on 23:00 or 23:59
	function automatic hm_t apply_action(input hm_t t, input action_t act);
		hm_t r;
		r = t;
		unique case (act)
			ACT_HOUR_UP: begin
				if (t.hrs == HourWidth'(LastHour)) begin
					r.hrs  = '0;
					r.mins = '0;
				end else begin
					r.hrs = t.hrs + 1'b1;
				end
			end
			ACT_HOUR_DOWN: begin
				if (t.hrs == '0) begin
					r.hrs  = HourWidth'(LastHour);
					r.mins = '0;
				end else begin
					r.hrs = t.hrs - 1'b1;
				end
			end
			ACT_MIN_UP: begin
				if (t.mins == MinWidth'(LastMinute)) begin
					r.mins = '0;
					r.hrs  = (t.hrs == HourWidth'(LastHour)) ? '0 : t.hrs + 1'b1;
				end else begin
					r.mins = t.mins + 1'b1;
				end
			end
			ACT_MIN_DOWN: begin
				if (t.mins == '0) begin
					r.mins = MinWidth'(LastMinute);
					r.hrs  = (t.hrs == '0) ? HourWidth'(LastHour) : t.hrs - 1'b1;
				end else begin
					r.mins = t.mins - 1'b1;
				end
			end
			default: r = t;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/clock_24h_with_set_buttons.sv @@
`default_nettype none

// 24-hour clock with four set buttons and seven-segment digit patterns.
// Request channel (req_valid/req_ready): op 0 is a half-second tick, op 1 a
// debounced, active-low button sample in button_levels. Every request gives
// exactly one response on rsp_valid/rsp_ready carrying the four digit
// patterns, the colon phase and the second of the day after that request.
// The clock state itself is the response register: a request is applied in
// the cycle it is accepted and its response is valid on the next cycle.
// Only ticks refresh the digit patterns. A request is taken every cycle as
// long as the response slot is empty or being drained in the same cycle,
// giving one request per cycle sustained; a stalled receiver holds the
// response and backs up req_ready until it is taken.
// The button action map is written through cfg_wr_en/cfg_wr_data with no
// wait; write it only while no request is outstanding.
// Reset clears the time to 00:00:00, the phase and the last button sample,
// loads the patterns of 0,1,2,3 and the default action map; no response is
// pending after reset.
module clock_24h_with_set_buttons (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        op,
	input  wire logic [3:0]  button_levels,

	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [7:0]       hours_tens_segments,
	output logic [7:0]       hours_ones_segments,
	output logic [7:0]       minutes_tens_segments,
	output logic [7:0]       minutes_ones_segments,
	output logic             colon_lit,
	output logic [16:0]      second_of_day,

	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data
);

	localparam int unsigned SW = c24h_pkg::SecWidth;
	localparam int unsigned HW = c24h_pkg::HourWidth;
	localparam int unsigned MW = c24h_pkg::MinWidth;
	localparam int unsigned NB = c24h_pkg::NumButtons;

	// Clock state; doubles as the response register
	logic                  rsp_valid_q;
	logic [7:0]            action_map_q;
	logic                  half_phase_q;
	logic [SW-1:0]         day_sec_q;
	logic [HW-1:0]         hrs_q;
	logic [MW-1:0]         mins_q;
	logic [MW-1:0]         secs_q;
	logic [NB-1:0]         last_buttons_q;
	c24h_pkg::seg_t        digits_q [c24h_pkg::NumDigits];

	logic                  accept;
	logic                  sec_step;
	logic                  sec_wrap;
	logic                  min_wrap;
	logic                  hour_wrap;
	logic [HW-1:0]         tick_hrs;
	logic [MW-1:0]         tick_mins;
	logic [MW-1:0]         tick_secs;
	logic [SW-1:0]         tick_day_sec;
	c24h_pkg::hm_t         btn_hm;
	logic [SW-1:0]         btn_day_sec;
	logic                  btn_change;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// Tick path: count one second on the falling half of the phase
	always_comb begin
		sec_step  = half_phase_q;
		sec_wrap  = secs_q == MW'(c24h_pkg::LastSecond);
		min_wrap  = sec_wrap && (mins_q == MW'(c24h_pkg::LastMinute));
		hour_wrap = min_wrap && (hrs_q == HW'(c24h_pkg::LastHour));
		tick_secs    = secs_q;
		tick_mins    = mins_q;
		tick_hrs     = hrs_q;
		tick_day_sec = day_sec_q;
		if (sec_step) begin
			tick_secs = sec_wrap ? '0 : secs_q + 1'b1;
			if (sec_wrap) begin
				tick_mins = min_wrap ? '0 : mins_q + 1'b1;
			end
			if (min_wrap) begin
				tick_hrs = hour_wrap ? '0 : hrs_q + 1'b1;
			end
			tick_day_sec = (day_sec_q == SW'(c24h_pkg::DaySeconds - 1)) ? '0
			                                                            : day_sec_q + 1'b1;
		end
	end

	// Button path: new presses handled in button order, seconds dropped
	always_comb begin
		btn_change = button_levels != last_buttons_q;
		btn_hm.hrs  = hrs_q;
		btn_hm.mins = mins_q;
		for (int i = 0; i < NB; i++) begin
			if (!button_levels[i] && last_buttons_q[i]) begin
				btn_hm = c24h_pkg::apply_action(btn_hm,
				                                c24h_pkg::action_t'(action_map_q[2*i +: 2]));
			end
		end
		btn_day_sec = SW'(btn_hm.hrs) * SW'(c24h_pkg::HourSeconds)
		            + SW'(btn_hm.mins) * SW'(c24h_pkg::MinuteSeconds);
	end

	// State and response update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q    <= 1'b0;
			action_map_q   <= c24h_pkg::ActionMapReset;
			half_phase_q   <= 1'b0;
			day_sec_q      <= '0;
			hrs_q          <= '0;
			mins_q         <= '0;
			secs_q         <= '0;
			last_buttons_q <= '0;
			digits_q[0]    <= c24h_pkg::glyph(4'd0);
			digits_q[1]    <= c24h_pkg::glyph(4'd1);
			digits_q[2]    <= c24h_pkg::glyph(4'd2);
			digits_q[3]    <= c24h_pkg::glyph(4'd3);
		end else begin
			if (cfg_wr_en) begin
				action_map_q <= cfg_wr_data;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept && !op) begin
				half_phase_q <= !half_phase_q;
				secs_q       <= tick_secs;
				mins_q       <= tick_mins;
				hrs_q        <= tick_hrs;
				day_sec_q    <= tick_day_sec;
				digits_q[0]  <= c24h_pkg::glyph(4'(c24h_pkg::tens_of(MW'(tick_hrs))));
				digits_q[1]  <= c24h_pkg::glyph(c24h_pkg::ones_of(MW'(tick_hrs)));
				digits_q[2]  <= c24h_pkg::glyph(4'(c24h_pkg::tens_of(tick_mins)));
				digits_q[3]  <= c24h_pkg::glyph(c24h_pkg::ones_of(tick_mins));
			end else if (accept && op && btn_change) begin
				secs_q         <= '0;
				mins_q         <= btn_hm.mins;
				hrs_q          <= btn_hm.hrs;
				day_sec_q      <= btn_day_sec;
				last_buttons_q <= button_levels;
			end
		end
	end

	assign rsp_valid             = rsp_valid_q;
	assign hours_tens_segments   = digits_q[0];
	assign hours_ones_segments   = digits_q[1];
	assign minutes_tens_segments = digits_q[2];
	assign minutes_ones_segments = digits_q[3];
	assign colon_lit             = half_phase_q;
	assign second_of_day         = day_sec_q;

endmodule

`default_nettype wire
